FILE: src/grr_pkg.sv
`timescale 1ns / 1ps
package grr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_FG_COLOR   = 2'd0;
  localparam logic [1:0] REG_BG_COLOR   = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;
  localparam logic [1:0] REG_FONT_WIDTH = 2'd3;

  // Input command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam int BYTE_BITS = 8;
  localparam int COLOR_W   = 16;
  localparam int SCALE_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int GLYPH_COUNT_DEF    = 256;
  localparam int ROWS_PER_GLYPH_DEF = 8;
  localparam int MAX_SCALE_DEF      = 8;

  localparam logic [COLOR_W-1:0] FG_RESET    = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET    = 16'h0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
  localparam logic [SCALE_W-1:0] WIDTH_RESET = 4'd8;

  // One row handed from the read stage to the pixel emitter
  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] pattern;
    logic [COLOR_W-1:0]   on_col;
    logic [COLOR_W-1:0]   off_col;
    logic [SCALE_W-1:0]   scale;   // already clamped to 1..max
    logic [SCALE_W-1:0]   width;   // already clamped to 1..8
  } row_load_t;

  // Clamp a 4-bit field into 1..hi
  function automatic logic [SCALE_W-1:0] clamp_field(input logic [SCALE_W-1:0] v,
                                                     input logic [SCALE_W-1:0] hi);
    logic [SCALE_W-1:0] r;
    r = v;
    if (v == '0) r = SCALE_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: src/grr_glyph_mem.sv
`timescale 1ns / 1ps
module grr_glyph_mem #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [grr_pkg::BYTE_BITS-1:0] wdata,
  output logic [grr_pkg::BYTE_BITS-1:0] rdata
);
  import grr_pkg::*;

  logic [BYTE_BITS-1:0] mem [DEPTH];
  logic [BYTE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/grr_pixel_emitter.sv
`timescale 1ns / 1ps
module grr_pixel_emitter #(
  parameter int MAX_SCALE = grr_pkg::MAX_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  grr_pkg::row_load_t          ld,
  output logic                        drained,
  output logic                        out_valid,
  output logic [grr_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                        out_last_pixel
);
  import grr_pkg::*;

  localparam int CNT_W = $clog2(BYTE_BITS * MAX_SCALE + 1);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [BYTE_BITS-1:0] bits_r, bits_nxt;
  logic [SCALE_W-1:0]   rep_r, rep_nxt;
  logic [SCALE_W-1:0]   sc_r, sc_nxt;
  logic [COLOR_W-1:0]   on_r, on_nxt;
  logic [COLOR_W-1:0]   off_r, off_nxt;
  logic [CNT_W-1:0]     total;

  assign total = CNT_W'(ld.width) * CNT_W'(ld.scale);

  always_comb begin
    cnt_nxt  = cnt_r;
    bits_nxt = bits_r;
    rep_nxt  = rep_r;
    sc_nxt   = sc_r;
    on_nxt   = on_r;
    off_nxt  = off_r;
    if (ld.valid) begin
      cnt_nxt  = total;
      bits_nxt = ld.pattern;
      rep_nxt  = '0;
      sc_nxt   = ld.scale;
      on_nxt   = ld.on_col;
      off_nxt  = ld.off_col;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (rep_r == sc_r - SCALE_W'(1)) begin
        rep_nxt  = '0;
        bits_nxt = {bits_r[BYTE_BITS-2:0], 1'b0};
      end else begin
        rep_nxt = rep_r + SCALE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    rep_r  <= rep_nxt;
    sc_r   <= sc_nxt;
    on_r   <= on_nxt;
    off_r  <= off_nxt;
  end

  assign out_valid       = (cnt_r != '0);
  assign out_pixel_color = bits_r[BYTE_BITS-1] ? on_r : off_r;
  assign out_last_pixel  = (cnt_r == CNT_W'(1));
  assign drained         = (cnt_r <= CNT_W'(2));

  // a new row only lands on the last pixel of the previous one or on idle
  a_load_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ld.valid |-> (cnt_r <= CNT_W'(1)))
    else $error("row loaded while previous row still emitting");

  a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ld.valid |=> out_valid)
    else $error("loaded row produced no pixel");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_pixel && !ld.valid) |=> !out_valid)
    else $error("pixels continue past the last one");

  a_rep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rep_r < sc_r))
    else $error("repeat counter outside scale");

endmodule

FILE: src/glyph_row_rasterizer.sv
`timescale 1ns / 1ps
// Glyph row rasterizer: text-mode character generator with horizontal scaling.
// Input channel: a word is taken at a clock edge with start high and busy low.
//   cmd load writes font_byte into the glyph store (no output words).
//   cmd render reads one glyph row and emits font_width * scale RGB565 pixels,
//   left to right, each font dot repeated scale times; the last is flagged.
// Output channel: out_valid strobes each pixel word for exactly one cycle;
//   the receiver cannot hold it off, so nothing here waits on the sink.
// Pipeline: the glyph byte is read at the accept edge and the emitter loads at
//   the next edge, after which the first pixel is on the outputs.
// Throughput: one pixel per cycle, set by the single output port. A render
//   yields font_width * scale pixels (1..64); busy drops while the
//   second-to-last pixel is out so the next row follows with no gap. A
//   one-pixel row still passes through both steps (read, then emit). Loads,
//   like renders, wait while busy is high.
// Config: cfg_we writes register cfg_index (fg, bg, scale, font_width) at once;
//   the user must write only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous): registers return to white on black,
//   scale 1, width 8; the pipeline empties. The glyph store is not cleared.
module glyph_row_rasterizer #(
  parameter int GLYPH_COUNT    = grr_pkg::GLYPH_COUNT_DEF,
  parameter int ROWS_PER_GLYPH = grr_pkg::ROWS_PER_GLYPH_DEF,
  parameter int MAX_SCALE      = grr_pkg::MAX_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_we,
  input  logic [grr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grr_pkg::COLOR_W-1:0]   cfg_data,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_char_code,
  input  logic [2:0]                    in_glyph_row,
  input  logic [grr_pkg::BYTE_BITS-1:0] in_font_byte,
  input  logic                          in_invert,
  // pixel channel
  output logic                          out_valid,
  output logic [grr_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic                          out_last_pixel
);
  import grr_pkg::*;

  localparam int DEPTH  = GLYPH_COUNT * ROWS_PER_GLYPH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(MAX_SCALE);
  localparam logic [SCALE_W-1:0] WIDTH_MAX = SCALE_W'(BYTE_BITS);

  // configuration registers
  logic [COLOR_W-1:0] fg_r, bg_r;
  logic [SCALE_W-1:0] scale_r, width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r    <= FG_RESET;
      bg_r    <= BG_RESET;
      scale_r <= SCALE_RESET;
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG_COLOR:   fg_r    <= cfg_data;
        REG_BG_COLOR:   bg_r    <= cfg_data;
        REG_SCALE:      scale_r <= cfg_data[SCALE_W-1:0];
        REG_FONT_WIDTH: width_r <= cfg_data[SCALE_W-1:0];
        default:        ;
      endcase
    end
  end

  // accept and address decode
  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic              mem_wr, mem_rd;
  logic              drained;

  assign accept   = start && !busy;
  assign in_range = (32'(in_char_code) < GLYPH_COUNT) && (32'(in_glyph_row) < ROWS_PER_GLYPH);
  assign addr     = ADDR_W'(32'(in_char_code) * ROWS_PER_GLYPH + 32'(in_glyph_row));
  assign mem_wr   = accept && (in_cmd == CMD_LOAD) && in_range;
  assign mem_rd   = accept && (in_cmd == CMD_RENDER) && in_range;

  // Load and render never share a cycle, and a read registered at the edge
  // after a write sees the new byte, so no forwarding is needed.
  logic [BYTE_BITS-1:0] rd_data;

  grr_glyph_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .wr_en (mem_wr),
    .rd_en (mem_rd),
    .addr  (addr),
    .wdata (in_font_byte),
    .rdata (rd_data)
  );

  // read stage: render word in flight while the glyph byte comes out
  logic s1_valid_r, s1_valid_nxt;
  logic s1_ok_r;
  logic s1_inv_r;

  assign s1_valid_nxt = accept && (in_cmd == CMD_RENDER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r  <= in_range;
      s1_inv_r <= in_invert;
    end
  end

  row_load_t ld;

  always_comb begin
    ld.valid   = s1_valid_r;
    ld.pattern = s1_ok_r ? rd_data : '0;      // out-of-range row renders blank
    ld.on_col  = s1_inv_r ? bg_r : fg_r;       // cursor swaps the colors
    ld.off_col = s1_inv_r ? fg_r : bg_r;
    ld.scale   = clamp_field(scale_r, SCALE_MAX);
    ld.width   = clamp_field(width_r, WIDTH_MAX);
  end

  grr_pixel_emitter #(
    .MAX_SCALE (MAX_SCALE)
  ) u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld              (ld),
    .drained         (drained),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  // The emitter must be on its last pixel (or idle) when a row arrives,
  // in the cycle after the accept edge.
  assign busy = s1_valid_r || !drained;

  a_no_accept_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !accept)
    else $error("word accepted while a row read is pending");

  a_render_reaches_emitter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_RENDER) |=> (s1_valid_r ##1 out_valid))
    else $error("render word produced no pixels");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_LOAD) |=> !s1_valid_r)
    else $error("load word started a render");

endmodule

FILE: tb/glyph_row_rasterizer_tb.sv
`timescale 1ns / 1ps
// Checks the glyph row rasterizer end to end. Directed words hit the reset
// colors, every command, invert, glyph overwrite and the clamping of scale and
// font width (zero and above range). After that, random phases run with fresh
// register settings, mixed load/render traffic and random idle gaps on the
// sender. A shadow glyph store and register set predict every pixel word.
module glyph_row_rasterizer_tb;
  import grr_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_WORDS  = 38;      // 10 x 38 = ~380 random words
  localparam int SETTLE_CYCLES = 4;      // emitter latency plus margin

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;
  logic                 start;
  logic                 busy;
  logic                 in_cmd;
  logic [7:0]           in_char_code;
  logic [2:0]           in_glyph_row;
  logic [BYTE_BITS-1:0] in_font_byte;
  logic                 in_invert;
  logic                 out_valid;
  logic [COLOR_W-1:0]   out_pixel_color;
  logic                 out_last_pixel;

  glyph_row_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_glyph_row   (in_glyph_row),
    .in_font_byte   (in_font_byte),
    .in_invert      (in_invert),
    .out_valid      (out_valid),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  // Shadow of the block: glyph store, which entries hold a real byte,
  // and the four registers as last written.
  logic [7:0]         font_shadow [0:2047];
  bit                 font_written [0:2047];
  int                 written_addrs [$];
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [SCALE_W-1:0] scale_reg;
  logic [SCALE_W-1:0] width_reg;

  pixel_t pending_pixels [$];  // pixel words still owed by the block
  int     mismatch_count;
  int     cycle_count;
  bit     gaps_on;             // sender idles at random when set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing pixel ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  // Expected pixels of one rendered row: clamp scale and width to 1..max,
  // walk dots MSB first, repeat each one scale times, flag the last word.
  function automatic void predict_row_pixels(input logic [7:0] pattern, input logic inv);
    logic [SCALE_W-1:0] sc;
    logic [SCALE_W-1:0] fw;
    logic [COLOR_W-1:0] on_c;
    logic [COLOR_W-1:0] off_c;
    int                 total;
    int                 n;
    pixel_t             px;
    sc = scale_reg;
    if (sc == '0) sc = SCALE_W'(1);
    else if (sc > MAX_SCALE_DEF) sc = SCALE_W'(MAX_SCALE_DEF);
    fw = width_reg;
    if (fw == '0) fw = SCALE_W'(1);
    else if (fw > BYTE_BITS) fw = SCALE_W'(BYTE_BITS);
    on_c  = inv ? bg_color : fg_color;
    off_c = inv ? fg_color : bg_color;
    total = int'(fw) * int'(sc);
    n = 0;
    for (int dot = 0; dot < fw; dot++) begin
      for (int rep = 0; rep < sc; rep++) begin
        px.color = pattern[7 - dot] ? on_c : off_c;
        px.last  = (n == total - 1);
        pending_pixels.push_back(px);
        n++;
      end
    end
  endfunction

  // Pixel checker: every strobed word must match the oldest expectation.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel word color=%h last=%b",
                                  out_pixel_color, out_last_pixel));
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_color !== want.color)
          report_mismatch($sformatf("pixel_color got %h want %h",
                                    out_pixel_color, want.color));
        if (out_last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel got %b want %b",
                                    out_last_pixel, want.last));
      end
    end
  end

  // Mostly short gaps, now and then a long one; none when gaps are off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one word; start stays up until the edge that takes it.
  task automatic send_word(input logic cmd, input logic [7:0] code,
                           input logic [2:0] row, input logic [7:0] fbyte,
                           input logic inv);
    logic [10:0] addr;
    addr = {code, row};
    @(negedge clk);
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_char_code <= code;
    in_glyph_row <= row;
    in_font_byte <= fbyte;
    in_invert    <= inv;
    @(posedge clk);
    while (busy) @(posedge clk);
    // word taken at this edge
    if (cmd == CMD_LOAD) begin
      font_shadow[addr] = fbyte;
      if (!font_written[addr]) begin
        font_written[addr] = 1'b1;
        written_addrs.push_back(int'(addr));
      end
    end else begin
      predict_row_pixels(font_shadow[addr], inv);
    end
    idle_cycles(pick_gap());
  endtask

  // Sender goes quiet until every owed pixel is out, then lets the
  // pipeline empty (a trailing load leaves no pixel to wait on).
  task automatic drain_pixels();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FG_COLOR:   fg_color  = data;
      REG_BG_COLOR:   bg_color  = data;
      REG_SCALE:      scale_reg = data[SCALE_W-1:0];
      REG_FONT_WIDTH: width_reg = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all_regs(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                              input logic [15:0] sc, input logic [15:0] fw);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_SCALE, sc);
    write_reg(REG_FONT_WIDTH, fw);
  endtask

  // Scale / width value: mostly in range, sometimes zero or past the top.
  // Upper data bits carry junk; only the low nibble is a register.
  function automatic logic [15:0] pick_dim();
    int r;
    logic [3:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) v = 4'd0;
    else if (r < 20) v = 4'($urandom_range(9, 15));
    else v = 4'($urandom_range(1, 8));
    return {12'($urandom_range(0, 4095)), v};
  endfunction

  function automatic logic [7:0] pick_font_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Reset colors (white on black, scale 1, width 8), both commands,
  // invert, and overwriting a glyph row.
  task automatic test_reset_defaults();
    gaps_on = 1'b0;
    send_word(CMD_LOAD, 8'h00, 3'd0, 8'h81, 1'b1);
    send_word(CMD_LOAD, 8'hFF, 3'd7, 8'hFF, 1'b0);
    send_word(CMD_LOAD, 8'h55, 3'd3, 8'h00, 1'b1);
    send_word(CMD_LOAD, 8'hAA, 3'd4, 8'h5A, 1'b0);
    send_word(CMD_RENDER, 8'h00, 3'd0, 8'hFF, 1'b0);
    send_word(CMD_RENDER, 8'hFF, 3'd7, 8'h00, 1'b0);
    send_word(CMD_RENDER, 8'h55, 3'd3, 8'hA5, 1'b1);
    send_word(CMD_RENDER, 8'hAA, 3'd4, 8'h5A, 1'b1);
    send_word(CMD_RENDER, 8'h00, 3'd0, 8'h00, 1'b1);
    // overwrite, then read straight back
    send_word(CMD_LOAD, 8'hAA, 3'd4, 8'hC3, 1'b0);
    send_word(CMD_RENDER, 8'hAA, 3'd4, 8'h3C, 1'b0);
    drain_pixels();
  endtask

  // Widest row (64 words), narrowest (1 word), zero and over-range clamps.
  task automatic test_config_extremes();
    logic [COLOR_W-1:0] fgs [5] = '{16'h0000, 16'hF800, 16'h001F, 16'h5A5A, 16'hFFFF};
    logic [COLOR_W-1:0] bgs [5] = '{16'hFFFF, 16'h07E0, 16'hA5A5, 16'h1234, 16'h0000};
    logic [15:0]        scs [5] = '{16'd8, 16'd1, 16'd0, 16'd15, 16'd3};
    logic [15:0]        fws [5] = '{16'd8, 16'd1, 16'd0, 16'd15, 16'd5};
    gaps_on = 1'b1;
    for (int i = 0; i < 5; i++) begin
      set_all_regs(fgs[i], bgs[i], scs[i], fws[i]);
      send_word(CMD_RENDER, 8'hAA, 3'd4, 8'h00, i[0]);
      send_word(CMD_RENDER, 8'h00, 3'd0, 8'hFF, ~i[0]);
      drain_pixels();
    end
  endtask

  // Random phases: new settings each time, ~70% renders of loaded rows,
  // loads anywhere in the store, gaps on or off per phase.
  task automatic test_random_traffic();
    logic [10:0] addr;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      set_all_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   pick_dim(), pick_dim());
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          addr = 11'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
          send_word(CMD_RENDER, addr[10:3], addr[2:0], 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end else begin
          addr = 11'($urandom_range(0, 2047));
          send_word(CMD_LOAD, addr[10:3], addr[2:0], pick_font_byte(),
                    1'($urandom_range(0, 1)));
        end
        // hold off now and then until the emitter has caught up
        if ((phase == 1 && n == 15) || $urandom_range(0, 29) == 0)
          drain_pixels();
      end
      drain_pixels();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    start        = 1'b0;
    in_cmd       = CMD_LOAD;
    in_char_code = '0;
    in_glyph_row = '0;
    in_font_byte = '0;
    in_invert    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    gaps_on        = 1'b0;
    fg_color  = FG_RESET;
    bg_color  = BG_RESET;
    scale_reg = SCALE_RESET;
    width_reg = WIDTH_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic();

    drain_pixels();
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixel words never arrived", pending_pixels.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
